/* design/mswt_pkg.sv */
// Shared types and constants for the mode stack with toggle.
`default_nettype none
package mswt_pkg;

  localparam int STACK_DEPTH_DEF = 10;
  localparam int MODE_BITS_DEF   = 8;
  localparam int REQ_W           = 3;
  localparam int CODE_W          = 8;
  localparam int POS_W           = 4;
  localparam int COUNT_W         = 4;

  typedef enum logic [REQ_W-1:0] {
    REQ_SET    = 3'd0,
    REQ_PUSH   = 3'd1,
    REQ_POP    = 3'd2,
    REQ_TOGGLE = 3'd3,
    REQ_CHECK  = 3'd4
  } req_t;

  // Carried from a cell to the cell above it.
  typedef struct packed {
    logic occ;
    logic found;
    logic hit;
  } up_link_t;

  // Carried from a cell to the cell below it.
  typedef struct packed {
    logic occ;
    logic occ_next;
  } dn_link_t;

endpackage
`default_nettype wire

/* design/mswt_cell.sv */
// One stack cell: holds one entry and its occupancy, links to both neighbours.
`default_nettype none
module mswt_cell #(
  parameter int IDX       = 0,
  parameter int MODE_BITS = mswt_pkg::MODE_BITS_DEF,
  parameter int IW        = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  mswt_pkg::req_t        req,
  input  logic [MODE_BITS-1:0]  mode,
  input  logic                  chk_en,
  input  logic [IW-1:0]         target,
  input  mswt_pkg::up_link_t    up_in,
  output mswt_pkg::up_link_t    up_out,
  input  mswt_pkg::dn_link_t    dn_in,
  output mswt_pkg::dn_link_t    dn_out,
  input  logic [MODE_BITS-1:0]  above_entry,
  output logic [MODE_BITS-1:0]  entry_out,
  input  logic [MODE_BITS-1:0]  top_in,
  output logic [MODE_BITS-1:0]  top_out
);

  localparam bit FIRST = (IDX == 0);

  logic [MODE_BITS-1:0] entry;
  logic [MODE_BITS-1:0] entry_next;
  logic                 occ;
  logic                 occ_next;
  logic                 below_occ;
  logic                 match;
  logic                 found;

  always_comb begin
    below_occ = FIRST ? 1'b1 : up_in.occ;
    match     = occ && (entry == mode);
    found     = up_in.found | match;
  end

  always_comb begin
    entry_next = entry;
    occ_next   = occ;
    unique case (req)
      mswt_pkg::REQ_SET: begin
        if (FIRST) begin
          entry_next = mode;
          occ_next   = 1'b1;
        end else begin
          occ_next = 1'b0;
        end
      end
      mswt_pkg::REQ_PUSH: begin
        if (!occ && below_occ) begin
          entry_next = mode;
          occ_next   = 1'b1;
        end
      end
      mswt_pkg::REQ_POP: begin
        if (FIRST) begin
          occ_next = 1'b1;
          if (!dn_in.occ) begin
            entry_next = '0;
          end
        end else if (occ && !dn_in.occ) begin
          occ_next = 1'b0;
        end
      end
      mswt_pkg::REQ_TOGGLE: begin
        if (found) begin
          entry_next = above_entry;
          occ_next   = dn_in.occ;
        end else if (!occ && below_occ) begin
          entry_next = mode;
          occ_next   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    up_out.occ      = occ;
    up_out.found    = found;
    up_out.hit      = up_in.hit | (chk_en && match && (target == IW'(IDX)));
    dn_out.occ      = occ;
    dn_out.occ_next = occ_next;
    entry_out       = entry;
    top_out         = (occ_next && !dn_in.occ_next) ? entry_next : top_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
      occ   <= FIRST;
    end else if (en) begin
      entry <= entry_next;
      occ   <= occ_next;
    end
  end

endmodule
`default_nettype wire

/* design/mode_stack_with_toggle_core.sv */
// Top level of the mode stack with toggle: row of cells, fill count, result register.
// Each accepted input beat gives its result beat in the cycle after it is accepted.
// Throughput: one request per cycle while results are taken; cells search and shift.
// A new beat is taken while a result waits only if that result is taken in the same cycle.
// Reset (synchronous, active high): the stack holds the single mode 0, no result pending.
`default_nettype none
module mode_stack_with_toggle_core #(
  parameter int STACK_DEPTH = mswt_pkg::STACK_DEPTH_DEF,
  parameter int MODE_BITS   = mswt_pkg::MODE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mswt_pkg::REQ_W-1:0]    req_type,
  input  logic [mswt_pkg::CODE_W-1:0]   mode_code,
  input  logic [mswt_pkg::POS_W-1:0]    depth_from_top,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          check_hit,
  output logic [mswt_pkg::COUNT_W-1:0]  entry_count,
  output logic [mswt_pkg::CODE_W-1:0]   top_entry,
  output logic                          push_dropped
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int IW = $clog2(STACK_DEPTH);
  localparam int PW = (CW > mswt_pkg::POS_W) ? CW : mswt_pkg::POS_W;

  logic                 accept;
  mswt_pkg::req_t       req;
  logic [MODE_BITS-1:0] mode;
  logic [CW-1:0]        fill;
  logic [CW-1:0]        fill_next;
  logic [PW-1:0]        fill_w;
  logic [PW-1:0]        pos_w;
  logic [PW-1:0]        diff;
  logic                 chk_en;
  logic [IW-1:0]        target;
  logic                 full;
  logic                 found_any;
  logic                 dropped;

  mswt_pkg::up_link_t   up_l    [STACK_DEPTH+1];
  mswt_pkg::dn_link_t   dn_l    [STACK_DEPTH];
  logic [MODE_BITS-1:0] entry_l [STACK_DEPTH];
  logic [MODE_BITS-1:0] top_l   [STACK_DEPTH];

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign req      = mswt_pkg::req_t'(req_type);
  assign mode     = MODE_BITS'(mode_code);

  always_comb begin
    fill_w = PW'(fill);
    pos_w  = PW'(depth_from_top);
    diff   = fill_w - pos_w;
    chk_en = (req == mswt_pkg::REQ_CHECK) && (pos_w != '0) && (pos_w <= fill_w);
    target = IW'(diff);
  end

  assign up_l[0] = '0;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    mswt_pkg::dn_link_t   dn_in;
    logic [MODE_BITS-1:0] above_entry;
    logic [MODE_BITS-1:0] top_in;

    if (i == STACK_DEPTH - 1) begin : g_end
      assign dn_in       = '0;
      assign above_entry = '0;
      assign top_in      = '0;
    end else begin : g_mid
      assign dn_in       = dn_l[i+1];
      assign above_entry = entry_l[i+1];
      assign top_in      = top_l[i+1];
    end

    mswt_cell #(
      .IDX       (i),
      .MODE_BITS (MODE_BITS),
      .IW        (IW)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .en          (accept),
      .req         (req),
      .mode        (mode),
      .chk_en      (chk_en),
      .target      (target),
      .up_in       (up_l[i]),
      .up_out      (up_l[i+1]),
      .dn_in       (dn_in),
      .dn_out      (dn_l[i]),
      .above_entry (above_entry),
      .entry_out   (entry_l[i]),
      .top_in      (top_in),
      .top_out     (top_l[i])
    );
  end

  assign full      = up_l[STACK_DEPTH].occ;
  assign found_any = up_l[STACK_DEPTH].found;

  always_comb begin
    fill_next = fill;
    dropped   = 1'b0;
    unique case (req)
      mswt_pkg::REQ_SET: begin
        fill_next = CW'(1);
      end
      mswt_pkg::REQ_PUSH: begin
        if (full) begin
          dropped = 1'b1;
        end else begin
          fill_next = fill + CW'(1);
        end
      end
      mswt_pkg::REQ_POP: begin
        fill_next = (fill > CW'(1)) ? fill - CW'(1) : CW'(1);
      end
      mswt_pkg::REQ_TOGGLE: begin
        if (found_any) begin
          fill_next = fill - CW'(1);
        end else if (full) begin
          dropped = 1'b1;
        end else begin
          fill_next = fill + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= CW'(1);
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        fill <= fill_next;
      end
      out_valid <= accept || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      check_hit    <= up_l[STACK_DEPTH].hit;
      entry_count  <= mswt_pkg::COUNT_W'(fill_next);
      top_entry    <= mswt_pkg::CODE_W'(top_l[0]);
      push_dropped <= dropped;
    end
  end

endmodule
`default_nettype wire
